### rtl/lrit_pkg.sv
// Shared constants and types for the line/rectangle intersection test pipeline.
`default_nettype none

package lrit_pkg;

  // Extra bits on coordinate differences: x1 - rect_left - width spans two more bits.
  localparam int DIFF_GUARD = 2;

  // Extra bits on the three-term numerator sums.
  localparam int SUM_GUARD = 2;

  // Position of each edge flag in the internal hit vector.
  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_TOP    = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_idx_t;

  localparam int NUM_EDGES = 4;

endpackage

`default_nettype wire

### rtl/line_rect_intersection_test_unit.sv
// Top level of the pipelined line segment versus rectangle intersection test.
`default_nettype none

// Takes one request per clock: busy is always low, so every cycle with start
// high is accepted. Each request gives one result from the last of four
// register stages, shown for one cycle with out_valid high. The stages are the
// coordinate differences, the sixteen signed products (ten distinct) of
// (COORD_BITS+2)-bit operands, the numerator sums, and the edge flags after
// the sign check. The receiver cannot stall, and the pipeline never does either.
module line_rect_intersection_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  signed [COORD_BITS-1:0] in_start_x,
  input  wire  signed [COORD_BITS-1:0] in_start_y,
  input  wire  signed [COORD_BITS-1:0] in_end_x,
  input  wire  signed [COORD_BITS-1:0] in_end_y,
  input  wire  signed [COORD_BITS-1:0] in_rect_left,
  input  wire  signed [COORD_BITS-1:0] in_rect_top,
  input  wire         [COORD_BITS-2:0] in_rect_w,
  input  wire         [COORD_BITS-2:0] in_rect_h,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic                         out_hit_left,
  output logic                         out_hit_right,
  output logic                         out_hit_top,
  output logic                         out_hit_bottom
);

  localparam int DW = COORD_BITS + lrit_pkg::DIFF_GUARD;

  logic signed [DW-1:0] dx, dy, ox, oy, ox_far, oy_far, wid, hgt;
  logic [lrit_pkg::NUM_EDGES-1:0] edge_hit;
  logic [lrit_pkg::NUM_EDGES-1:0] hits_r;
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: differences
  lrit_front #(.W(COORD_BITS)) u_front (
    .clk         (clk),
    .start_x     (in_start_x),
    .start_y     (in_start_y),
    .end_x       (in_end_x),
    .end_y       (in_end_y),
    .rect_left   (in_rect_left),
    .rect_top    (in_rect_top),
    .rect_w      (in_rect_w),
    .rect_h      (in_rect_h),
    .dx          (dx),
    .dy          (dy),
    .ox          (ox),
    .oy          (oy),
    .ox_far      (ox_far),
    .oy_far      (oy_far),
    .wid         (wid),
    .hgt         (hgt)
  );

  // Stages 2 and 3 plus sign check, one unit per edge
  lrit_edge #(.W(COORD_BITS)) u_edge_left (
    .clk (clk), .p (hgt), .q (dx), .r (ox),
    .s (dy), .t (ox), .u (dx), .v (oy),
    .hit (edge_hit[lrit_pkg::EDGE_LEFT])
  );

  lrit_edge #(.W(COORD_BITS)) u_edge_right (
    .clk (clk), .p (hgt), .q (dx), .r (ox_far),
    .s (dy), .t (ox_far), .u (dx), .v (oy),
    .hit (edge_hit[lrit_pkg::EDGE_RIGHT])
  );

  lrit_edge #(.W(COORD_BITS)) u_edge_top (
    .clk (clk), .p (wid), .q (dy), .r (oy),
    .s (dx), .t (oy), .u (dy), .v (ox),
    .hit (edge_hit[lrit_pkg::EDGE_TOP])
  );

  lrit_edge #(.W(COORD_BITS)) u_edge_bottom (
    .clk (clk), .p (wid), .q (dy), .r (oy_far),
    .s (dx), .t (oy_far), .u (dy), .v (ox),
    .hit (edge_hit[lrit_pkg::EDGE_BOTTOM])
  );

  // Valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= accept;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  // Stage 4: result register
  always_ff @(posedge clk) begin
    hits_r <= edge_hit;
  end

  assign out_valid      = out_vld_r;
  assign out_hit_left   = hits_r[lrit_pkg::EDGE_LEFT];
  assign out_hit_right  = hits_r[lrit_pkg::EDGE_RIGHT];
  assign out_hit_top    = hits_r[lrit_pkg::EDGE_TOP];
  assign out_hit_bottom = hits_r[lrit_pkg::EDGE_BOTTOM];
  assign out_hit        = |hits_r;

`ifndef SYNTHESIS
  // Every accepted request gives a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("request did not produce a result after four cycles");

  // A vertical edge of zero height is never hit
  a_left_height: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_left) |-> ($past(in_rect_h, 4) != '0))
    else $error("left edge hit reported on zero-height rectangle");

  // A horizontal edge of zero width is never hit
  a_top_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_top) |-> ($past(in_rect_w, 4) != '0))
    else $error("top edge hit reported on zero-width rectangle");

  // A zero-length segment hits nothing
  a_point_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |->
      ($past(in_start_x, 4) != $past(in_end_x, 4) ||
       $past(in_start_y, 4) != $past(in_end_y, 4)))
    else $error("hit reported for zero-length segment");
`endif

endmodule

`default_nettype wire

### rtl/lrit_front.sv
// First pipeline stage: segment deltas and offsets from the rectangle corners.
`default_nettype none

module lrit_front #(
  parameter int W = 16
) (
  input  wire                                          clk,
  input  wire  signed [W-1:0]                          start_x,
  input  wire  signed [W-1:0]                          start_y,
  input  wire  signed [W-1:0]                          end_x,
  input  wire  signed [W-1:0]                          end_y,
  input  wire  signed [W-1:0]                          rect_left,
  input  wire  signed [W-1:0]                          rect_top,
  input  wire         [W-2:0]                          rect_w,
  input  wire         [W-2:0]                          rect_h,
  output logic signed [W+lrit_pkg::DIFF_GUARD-1:0]     dx,
  output logic signed [W+lrit_pkg::DIFF_GUARD-1:0]     dy,
  output logic signed [W+lrit_pkg::DIFF_GUARD-1:0]     ox,
  output logic signed [W+lrit_pkg::DIFF_GUARD-1:0]     oy,
  output logic signed [W+lrit_pkg::DIFF_GUARD-1:0]     ox_far,
  output logic signed [W+lrit_pkg::DIFF_GUARD-1:0]     oy_far,
  output logic signed [W+lrit_pkg::DIFF_GUARD-1:0]     wid,
  output logic signed [W+lrit_pkg::DIFF_GUARD-1:0]     hgt
);

  localparam int DW = W + lrit_pkg::DIFF_GUARD;

  logic signed [DW-1:0] x1, y1, x2, y2, rl, rt, rw, rh;
  logic signed [DW-1:0] dx_nxt, dy_nxt, ox_nxt, oy_nxt, oxf_nxt, oyf_nxt;
  logic signed [DW-1:0] dx_r, dy_r, ox_r, oy_r, oxf_r, oyf_r, wid_r, hgt_r;

  // Widen everything to the difference width
  assign x1 = DW'(start_x);
  assign y1 = DW'(start_y);
  assign x2 = DW'(end_x);
  assign y2 = DW'(end_y);
  assign rl = DW'(rect_left);
  assign rt = DW'(rect_top);
  assign rw = $signed(DW'(rect_w));
  assign rh = $signed(DW'(rect_h));

  // Segment direction and start point relative to near and far edges
  always_comb begin
    dx_nxt  = x2 - x1;
    dy_nxt  = y2 - y1;
    ox_nxt  = x1 - rl;
    oy_nxt  = y1 - rt;
    oxf_nxt = x1 - rl - rw;
    oyf_nxt = y1 - rt - rh;
  end

  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    ox_r  <= ox_nxt;
    oy_r  <= oy_nxt;
    oxf_r <= oxf_nxt;
    oyf_r <= oyf_nxt;
    wid_r <= rw;
    hgt_r <= rh;
  end

  assign dx     = dx_r;
  assign dy     = dy_r;
  assign ox     = ox_r;
  assign oy     = oy_r;
  assign ox_far = oxf_r;
  assign oy_far = oyf_r;
  assign wid    = wid_r;
  assign hgt    = hgt_r;

endmodule

`default_nettype wire

### rtl/lrit_edge.sv
// One rectangle edge: product stage, numerator sum stage and sign check.
`default_nettype none

// Edge test in the form d = -(p*q), na = p*r, nb = s*t - u*v.
// Hit when d != 0 and na, nb both lie between 0 and d inclusive.
module lrit_edge #(
  parameter int W = 16
) (
  input  wire                                       clk,
  input  wire  signed [W+lrit_pkg::DIFF_GUARD-1:0]  p,
  input  wire  signed [W+lrit_pkg::DIFF_GUARD-1:0]  q,
  input  wire  signed [W+lrit_pkg::DIFF_GUARD-1:0]  r,
  input  wire  signed [W+lrit_pkg::DIFF_GUARD-1:0]  s,
  input  wire  signed [W+lrit_pkg::DIFF_GUARD-1:0]  t,
  input  wire  signed [W+lrit_pkg::DIFF_GUARD-1:0]  u,
  input  wire  signed [W+lrit_pkg::DIFF_GUARD-1:0]  v,
  output logic                                      hit
);

  localparam int DW = W + lrit_pkg::DIFF_GUARD;
  localparam int PW = 2 * DW;
  localparam int SW = PW + lrit_pkg::SUM_GUARD;

  logic signed [PW-1:0] pq_r, pr_r, st_r, uv_r;
  logic signed [PW-1:0] den_r;
  logic signed [SW-1:0] na_r, nas_r, nb_r, nbs_r;
  logic signed [SW-1:0] nb_nxt;

  // Products
  always_ff @(posedge clk) begin
    pq_r <= p * q;
    pr_r <= p * r;
    st_r <= s * t;
    uv_r <= u * v;
  end

  // Numerators and numerators offset by the negated denominator
  assign nb_nxt = SW'(st_r) - SW'(uv_r);

  always_ff @(posedge clk) begin
    den_r <= pq_r;
    na_r  <= SW'(pr_r);
    nas_r <= SW'(pr_r) + SW'(pq_r);
    nb_r  <= nb_nxt;
    nbs_r <= nb_nxt + SW'(pq_r);
  end

  // Sign check
  logic den_zero, den_neg;
  logic na_neg, na_le0, nas_neg, nas_le0;
  logic nb_neg, nb_le0, nbs_neg, nbs_le0;
  logic hit_dneg, hit_dpos;

  always_comb begin
    den_zero = (den_r == '0);
    den_neg  = den_r[PW-1];
    na_neg   = na_r[SW-1];
    na_le0   = na_neg || (na_r == '0);
    nas_neg  = nas_r[SW-1];
    nas_le0  = nas_neg || (nas_r == '0);
    nb_neg   = nb_r[SW-1];
    nb_le0   = nb_neg || (nb_r == '0);
    nbs_neg  = nbs_r[SW-1];
    nbs_le0  = nbs_neg || (nbs_r == '0);
    // p*q > 0 means d < 0: need d <= n <= 0
    hit_dneg = na_le0 && !nas_neg && nb_le0 && !nbs_neg;
    // p*q < 0 means d > 0: need 0 <= n <= d
    hit_dpos = !na_neg && nas_le0 && !nb_neg && nbs_le0;
    hit      = !den_zero && (den_neg ? hit_dpos : hit_dneg);
  end

endmodule

`default_nettype wire

### verif/line_rect_intersection_test_unit_test.sv
// Self-checking testbench for the line segment versus rectangle edge test unit.
module line_rect_intersection_test_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 400;
  localparam int DRAIN_CYCLES = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-2:0] extent_t;

  typedef struct {
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
    coord_t  rect_left;
    coord_t  rect_top;
    extent_t rect_w;
    extent_t rect_h;
  } segment_rect_t;

  // hit, left, right, top, bottom from MSB down
  typedef struct packed {
    logic hit;
    logic left;
    logic right;
    logic top;
    logic bottom;
  } hit_flags_t;

  typedef struct {
    segment_rect_t req;
    bit            fixed;
    hit_flags_t    flags;
  } directed_row_t;

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  coord_t  in_start_x;
  coord_t  in_start_y;
  coord_t  in_end_x;
  coord_t  in_end_y;
  coord_t  in_rect_left;
  coord_t  in_rect_top;
  extent_t in_rect_w;
  extent_t in_rect_h;
  logic    out_valid;
  logic    out_hit;
  logic    out_hit_left;
  logic    out_hit_right;
  logic    out_hit_top;
  logic    out_hit_bottom;

  hit_flags_t expected_hits[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         burst_left = 0;

  string flag_names[5] = '{"hit_bottom", "hit_top", "hit_right", "hit_left", "hit"};

  // Directed requests: fixed rows carry a hand-checked answer
  directed_row_t directed_rows[] = '{
    '{'{100, 100, 100, 100, 0, 0, 320, 320}, 1'b1, 5'b00000},       // zero-length segment
    '{'{-160, 80, 480, 80, 0, 0, 320, 160}, 1'b1, 5'b11100},        // horizontal through
    '{'{80, -160, 80, 480, 0, 0, 160, 320}, 1'b1, 5'b10011},        // vertical through
    '{'{0, 0, 320, 0, 0, 0, 320, 160}, 1'b1, 5'b11100},             // along top edge
    '{'{16, 16, 32, 32, 0, 0, 320, 320}, 1'b1, 5'b00000},           // fully inside
    '{'{1000, 1000, 2000, 1000, 0, 0, 16, 16}, 1'b1, 5'b00000},     // far outside
    '{'{-160, 80, 160, 80, 0, 0, 0, 320}, 1'b1, 5'b11100},          // zero width
    '{'{80, -160, 80, 160, 0, 0, 320, 0}, 1'b1, 5'b10011},          // zero height
    '{'{-16, -16, 16, 16, 0, 0, 0, 0}, 1'b1, 5'b00000},             // point rectangle
    '{'{-160, -160, 0, 0, 0, 0, 320, 320}, 1'b1, 5'b11010},         // ends on corner
    '{'{0, -80, 0, 400, 0, 0, 320, 320}, 1'b1, 5'b10011},           // overlaps left edge
    '{'{-160, 80, -1, 80, 0, 0, 320, 160}, 1'b1, 5'b00000},         // stops one lsb short
    '{'{32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767}, 1'b1, 5'b00000},
    '{'{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767}, 1'b0, 5'b00000},
    '{'{32767, -32768, -32768, 32767, 32767, 32767, 32767, 32767}, 1'b0, 5'b00000},
    '{'{-32768, 0, 32767, 0, -32768, -32768, 32767, 32767}, 1'b0, 5'b00000},
    '{'{-32768, 32767, 32767, -32768, 0, 0, 32767, 32767}, 1'b0, 5'b00000},
    '{'{0, -32768, 0, 32767, -1, -1, 1, 1}, 1'b0, 5'b00000},
    '{'{-1, -1, 1, 1, -1, -1, 2, 2}, 1'b0, 5'b00000}
  };

  line_rect_intersection_test_unit #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_start_x(in_start_x),
    .in_start_y(in_start_y),
    .in_end_x(in_end_x),
    .in_end_y(in_end_y),
    .in_rect_left(in_rect_left),
    .in_rect_top(in_rect_top),
    .in_rect_w(in_rect_w),
    .in_rect_h(in_rect_h),
    .out_valid(out_valid),
    .out_hit(out_hit),
    .out_hit_left(out_hit_left),
    .out_hit_right(out_hit_right),
    .out_hit_top(out_hit_top),
    .out_hit_bottom(out_hit_bottom)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Parametric crossing test of segment 1-2 against edge 3-4, no division
  function automatic logic edge_crossed(longint x1, longint y1, longint x2, longint y2,
                                        longint x3, longint y3, longint x4, longint y4);
    longint ex, ey, dx, dy, ox, oy, den, num_a, num_b;
    ex = x4 - x3;
    ey = y4 - y3;
    dx = x2 - x1;
    dy = y2 - y1;
    ox = x1 - x3;
    oy = y1 - y3;
    den = ey * dx - ex * dy;
    num_a = ex * oy - ey * ox;
    num_b = dx * oy - dy * ox;
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      num_a = -num_a;
      num_b = -num_b;
    end
    return num_a >= 0 && num_a <= den && num_b >= 0 && num_b <= den;
  endfunction

  function automatic hit_flags_t predict_hits(segment_rect_t r);
    longint x1, y1, x2, y2, lft, top, rgt, bot;
    logic [lrit_pkg::NUM_EDGES-1:0] crossed;
    hit_flags_t f;
    x1 = longint'(r.start_x);
    y1 = longint'(r.start_y);
    x2 = longint'(r.end_x);
    y2 = longint'(r.end_y);
    lft = longint'(r.rect_left);
    top = longint'(r.rect_top);
    rgt = lft + longint'(r.rect_w);
    bot = top + longint'(r.rect_h);
    crossed[lrit_pkg::EDGE_LEFT]   = edge_crossed(x1, y1, x2, y2, lft, top, lft, bot);
    crossed[lrit_pkg::EDGE_RIGHT]  = edge_crossed(x1, y1, x2, y2, rgt, top, rgt, bot);
    crossed[lrit_pkg::EDGE_TOP]    = edge_crossed(x1, y1, x2, y2, lft, top, rgt, top);
    crossed[lrit_pkg::EDGE_BOTTOM] = edge_crossed(x1, y1, x2, y2, lft, bot, rgt, bot);
    f.hit    = |crossed;
    f.left   = crossed[lrit_pkg::EDGE_LEFT];
    f.right  = crossed[lrit_pkg::EDGE_RIGHT];
    f.top    = crossed[lrit_pkg::EDGE_TOP];
    f.bottom = crossed[lrit_pkg::EDGE_BOTTOM];
    return f;
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v);
  endfunction

  // Mostly segments placed around a nearby rectangle, some fully random
  function automatic segment_rect_t make_random_request();
    segment_rect_t r;
    int mode, lft, top, w, h, sx, sy, ex, ey;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      r.start_x = coord_t'($urandom);
      r.start_y = coord_t'($urandom);
      r.end_x = coord_t'($urandom);
      r.end_y = coord_t'($urandom);
      r.rect_left = coord_t'($urandom);
      r.rect_top = coord_t'($urandom);
      r.rect_w = extent_t'($urandom);
      r.rect_h = extent_t'($urandom);
      return r;
    end
    lft = int'($urandom_range(0, 8192)) - 4096;
    top = int'($urandom_range(0, 8192)) - 4096;
    w = (mode == 3) ? $urandom_range(0, 32767) : $urandom_range(0, 480);
    h = (mode == 3) ? $urandom_range(0, 32767) : $urandom_range(0, 480);
    if (mode == 9) begin
      if ($urandom_range(0, 1)) w = 0;
      else h = 0;
    end
    sx = lft + int'($urandom_range(0, w + 400)) - 200;
    sy = top + int'($urandom_range(0, h + 400)) - 200;
    ex = lft + int'($urandom_range(0, w + 400)) - 200;
    ey = top + int'($urandom_range(0, h + 400)) - 200;
    case (mode)
      4: begin
        // start on a vertical edge, corners included
        sx = lft + ($urandom_range(0, 1) ? w : 0);
        sy = top + int'($urandom_range(0, h));
      end
      5: begin
        // axis-aligned, sometimes lying on an edge line
        if ($urandom_range(0, 1)) begin
          ey = sy;
          if ($urandom_range(0, 2) == 0) begin
            sy = top;
            ey = top;
          end
        end else begin
          ex = sx;
          if ($urandom_range(0, 2) == 0) begin
            sx = lft + w;
            ex = lft + w;
          end
        end
      end
      6: begin
        ex = sx;
        ey = sy;
      end
      7: begin
        // end on a horizontal edge
        ex = lft + int'($urandom_range(0, w));
        ey = top + ($urandom_range(0, 1) ? h : 0);
      end
      default: ;
    endcase
    r.start_x = clamp_coord(sx);
    r.start_y = clamp_coord(sy);
    r.end_x = clamp_coord(ex);
    r.end_y = clamp_coord(ey);
    r.rect_left = clamp_coord(lft);
    r.rect_top = clamp_coord(top);
    r.rect_w = extent_t'(w);
    r.rect_h = extent_t'(h);
    return r;
  endfunction

  // Present one request and hold it until the unit takes it
  task automatic issue(input segment_rect_t r, input hit_flags_t want);
    start <= 1'b1;
    in_start_x <= r.start_x;
    in_start_y <= r.start_y;
    in_end_x <= r.end_x;
    in_end_y <= r.end_y;
    in_rect_left <= r.rect_left;
    in_rect_top <= r.rect_top;
    in_rect_w <= r.rect_w;
    in_rect_h <= r.rect_h;
    do @(posedge clk); while (busy !== 1'b0);
    expected_hits.push_back(want);
  endtask

  // Random gap after a request: mostly none or short, a few long, some bursts
  task automatic idle_between();
    int pick, n;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      burst_left = $urandom_range(15, 40);
      return;
    end
    n = (pick < 60) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result is back
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  // Result checker: every strobe must match the oldest pending request
  always @(posedge clk) begin
    hit_flags_t want, got;
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        $error("out_valid: expected 0 or 1, got %b", out_valid);
        mismatch_count++;
      end else if (out_valid) begin
        got = {out_hit, out_hit_left, out_hit_right, out_hit_top, out_hit_bottom};
        if (expected_hits.size() == 0) begin
          $error("result strobe with no request pending: got %b", got);
          mismatch_count++;
        end else begin
          want = expected_hits.pop_front();
          for (int i = 0; i < 5; i++) begin
            if (got[i] !== want[i]) begin
              $error("%s: expected %b, got %b", flag_names[i], want[i], got[i]);
              mismatch_count++;
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus
  initial begin
    segment_rect_t r;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_start_x <= '0;
    in_start_y <= '0;
    in_end_x <= '0;
    in_end_y <= '0;
    in_rect_left <= '0;
    in_rect_top <= '0;
    in_rect_w <= '0;
    in_rect_h <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].req,
            directed_rows[i].fixed ? directed_rows[i].flags : predict_hits(directed_rows[i].req));
      idle_between();
    end
    wait_for_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      r = make_random_request();
      issue(r, predict_hits(r));
      if (n == RANDOM_REQUESTS / 2) wait_for_results();
      else idle_between();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
